/* rtl/awv_pkg.sv */
// ----------------------------------------------------------------------------
// awv_pkg
// Shared types and constants of the wavetable voice: item layouts, item kinds,
// register indexes, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
`default_nettype none

package awv_pkg;

    localparam int PHASE_FRAC = 16;
    localparam int STEP_W     = 24;
    localparam int ENV_W      = 17;
    localparam int SCALE_W    = 25;
    localparam int DAC_W      = 10;
    localparam int DAC_SUM_W  = 13;
    localparam int DAC_GAIN   = 270;
    localparam int DAC_BIAS   = 300;
    localparam int DAC_MAX    = 1023;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 24;

    localparam logic [ENV_W-1:0] ENV_ONE       = 17'h10000;
    localparam logic [15:0]      LFO_MIX_RESET = 16'h8000;

    // item kinds
    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd2;
    localparam logic [2:0] KIND_WAVE_WR  = 3'd3;
    localparam logic [2:0] KIND_LFO_WR   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_MIX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE     = 3'd7;

    typedef struct packed {
        logic [2:0]         kind;
        logic [23:0]        phase_step;
        logic [7:0]         table_index;
        logic signed [15:0] table_sample;
    } in_item_t;

    typedef struct packed {
        logic [DAC_W-1:0] dac_value;
        logic             voice_active;
    } out_item_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_LO   = 7'b0000100,
        ST_HI   = 7'b0001000,
        ST_MIX  = 7'b0010000,
        ST_PROD = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic note_on;
        logic note_end;
        logic wave_we;
        logic lfo_we;
        logic env_run;
        logic mul_lo;
        logic mul_hi;
        logic mix;
        logic mul_out;
        logic load_out;
    } ctl_t;

endpackage

`default_nettype wire

/* rtl/adsr_wavetable_voice_core.sv */
// ----------------------------------------------------------------------------
// adsr_wavetable_voice_core
// Tick items: stepped by the sequencer through READ, LO, HI, MIX, PROD and OUT
//   (split LFO multiply, converter scaling multiply) into the result register;
//   no new item is taken until OUT is left, and OUT waits while the result is held.
// Note on, note off and table write items: applied when taken, no result.
// Reset (rst_n, async, active low) resets the configuration, voice state and
//   control, not the tick pipeline or result data; tables are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_wavetable_voice_core #(
    parameter int TABLE_SIZE  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire awv_pkg::in_item_t             cmd,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output awv_pkg::out_item_t                 res,
    input  wire logic                          cfg_we,
    input  wire logic [awv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [awv_pkg::CFG_W-1:0]     cfg_data
);

    awv_pkg::ctl_t ctl;

    awv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .kind      (cmd.kind),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ctl       (ctl)
    );

    awv_dpath #(
        .TABLE_SIZE  (TABLE_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

endmodule

`default_nettype wire

/* rtl/awv_ram.sv */
// ----------------------------------------------------------------------------
// awv_ram
// Generic one-write one-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module awv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/awv_ctrl.sv */
// ----------------------------------------------------------------------------
// awv_ctrl
// Sequencer of the voice: takes items, issues state updates and table
// writes, steps a tick through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module awv_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [2:0]  kind,
    output logic             res_valid,
    input  wire logic        res_ready,
    output awv_pkg::ctl_t    ctl
);

    awv_pkg::state_t state_reg, state_next;
    logic            res_valid_reg, res_valid_next;
    logic            accept;

    assign cmd_ready = (state_reg == awv_pkg::ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            awv_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        awv_pkg::KIND_TICK:     state_next   = awv_pkg::ST_READ;
                        awv_pkg::KIND_NOTE_ON:  ctl.note_on  = 1'b1;
                        awv_pkg::KIND_NOTE_OFF: ctl.note_end = 1'b1;
                        awv_pkg::KIND_WAVE_WR:  ctl.wave_we  = 1'b1;
                        awv_pkg::KIND_LFO_WR:   ctl.lfo_we   = 1'b1;
                        default:                ;
                    endcase
                end
            end
            awv_pkg::ST_READ:
            begin
                ctl.env_run = 1'b1;
                state_next  = awv_pkg::ST_LO;
            end
            awv_pkg::ST_LO:
            begin
                ctl.mul_lo = 1'b1;
                state_next = awv_pkg::ST_HI;
            end
            awv_pkg::ST_HI:
            begin
                ctl.mul_hi = 1'b1;
                state_next = awv_pkg::ST_MIX;
            end
            awv_pkg::ST_MIX:
            begin
                ctl.mix    = 1'b1;
                state_next = awv_pkg::ST_PROD;
            end
            awv_pkg::ST_PROD:
            begin
                ctl.mul_out = 1'b1;
                state_next  = awv_pkg::ST_OUT;
            end
            awv_pkg::ST_OUT:
            begin
                // wait here until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = awv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = awv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= awv_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

`ifndef NO_ASSERTIONS
    a_tick_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && kind == awv_pkg::KIND_TICK)
            |=> state_reg == awv_pkg::ST_READ)
        else $error("tick item did not start the datapath sequence");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> (!res_valid_reg || res_ready))
        else $error("result register overwritten before it was taken");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == awv_pkg::ST_OUT))
        else $error("result appeared without a finished tick");

    a_hold_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == awv_pkg::ST_OUT && res_valid_reg && !res_ready)
            |=> state_reg == awv_pkg::ST_OUT)
        else $error("finished tick dropped while output was blocked");
`endif

endmodule

`default_nettype wire

/* rtl/awv_dpath.sv */
// ----------------------------------------------------------------------------
// awv_dpath
// Datapath of the voice: configuration registers, voice state, the wave and
// LFO tables, envelope update, LFO modulation and converter scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module awv_dpath #(
    parameter int TABLE_SIZE  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire awv_pkg::ctl_t                    ctl,
    input  wire awv_pkg::in_item_t                cmd,
    input  wire logic                             cfg_we,
    input  wire logic [awv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [awv_pkg::CFG_W-1:0]        cfg_data,
    output awv_pkg::out_item_t                    res
);

    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int PF         = awv_pkg::PHASE_FRAC;
    localparam int PHASE_W    = ((ADDR_W + PF > awv_pkg::STEP_W) ? ADDR_W + PF
                                                                 : awv_pkg::STEP_W) + 1;
    localparam int IP_W       = PHASE_W - PF;
    localparam int SB         = SAMPLE_BITS;
    localparam int A_W        = 2 * SB;
    localparam int LO_W       = SB + 16;
    localparam int HI_W       = SB + 17;
    localparam int P_W        = 2 * SB + 17;
    localparam int WM_W       = SB + 2;
    localparam int PROD_W     = awv_pkg::SCALE_W + 1 + WM_W;
    localparam int LFO_SHIFT  = SB - 1 + 15;
    localparam int DAC_SHIFT  = PF + SB - 1;
    localparam int ENV_W      = awv_pkg::ENV_W;
    localparam int ENV_CALC_W = ENV_W + 2;

    localparam logic [1:0] STAGE_ATTACK  = 2'd0;
    localparam logic [1:0] STAGE_DECAY   = 2'd1;
    localparam logic [1:0] STAGE_SUSTAIN = 2'd2;

    // configuration
    logic [1:0]                 mode_reg;
    logic [15:0]                start_delay_reg;
    logic [15:0]                lfo_mix_reg;
    logic [awv_pkg::STEP_W-1:0] lfo_step_reg;
    logic [ENV_W-1:0]           sustain_reg;
    logic [ENV_W-1:0]           attack_reg;
    logic [ENV_W-1:0]           decay_reg;
    logic [ENV_W-1:0]           release_reg;

    // voice state
    logic [PHASE_W-1:0]         wave_phase_reg, wave_phase_next;
    logic [PHASE_W-1:0]         lfo_phase_reg, lfo_phase_next;
    logic [awv_pkg::STEP_W-1:0] note_step_reg, note_step_next;
    logic [15:0]                delay_cnt_reg, delay_cnt_next;
    logic [ENV_W-1:0]           env_reg, env_next;
    logic [1:0]                 stage_reg, stage_next;
    logic                       released_reg, released_next;
    logic                       active_reg, active_next;

    // tick pipeline
    logic signed [SB-1:0]        w_reg, w_next;
    logic signed [A_W-1:0]       a_reg, a_next;
    logic        [LO_W-1:0]      lo_reg, lo_next;
    logic signed [HI_W-1:0]      hi_reg, hi_next;
    logic signed [WM_W-1:0]      wm_reg, wm_next;
    logic [awv_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic                        nogain_reg, nogain_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    awv_pkg::out_item_t          res_reg, res_next;

    logic [PHASE_W-1:0]          wave_wrapped, lfo_wrapped;
    logic [ADDR_W-1:0]           wave_raddr, lfo_raddr, tab_waddr;
    logic [SB-1:0]               wave_rdata, lfo_rdata;
    logic signed [SB-1:0]        wave_rd, lfo_rd;
    logic signed [SB-1:0]        sample_w;
    logic                        idx_ok;
    logic                        in_delay;

    logic signed [ENV_CALC_W-1:0] env_sum;
    logic [ENV_W-1:0]             env_calc;
    logic [1:0]                   stage_calc;
    logic                         active_calc;

    logic signed [P_W-1:0]        p_full, lfo_term;
    logic signed [PROD_W-1:0]     dac_off;
    logic signed [awv_pkg::DAC_SUM_W-1:0] dac_sum;

    // ---------------- configuration port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= '0;
            start_delay_reg <= '0;
            lfo_mix_reg     <= awv_pkg::LFO_MIX_RESET;
            lfo_step_reg    <= '0;
            sustain_reg     <= '0;
            attack_reg      <= '0;
            decay_reg       <= '0;
            release_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                awv_pkg::CFG_MODE:        mode_reg        <= cfg_data[1:0];
                awv_pkg::CFG_START_DELAY: start_delay_reg <= cfg_data[15:0];
                awv_pkg::CFG_LFO_MIX:     lfo_mix_reg     <= cfg_data[15:0];
                awv_pkg::CFG_LFO_STEP:    lfo_step_reg    <= cfg_data[23:0];
                awv_pkg::CFG_SUSTAIN:     sustain_reg     <= cfg_data[ENV_W-1:0];
                awv_pkg::CFG_ATTACK:      attack_reg      <= cfg_data[ENV_W-1:0];
                awv_pkg::CFG_DECAY:       decay_reg       <= cfg_data[ENV_W-1:0];
                awv_pkg::CFG_RELEASE:     release_reg     <= cfg_data[ENV_W-1:0];
                default:                  ;
            endcase
        end
    end

    // ---------------- tables ----------------
    generate
        if (SAMPLE_BITS >= 16)
        begin : g_widen
            assign sample_w = SB'($signed(cmd.table_sample)) <<< (SAMPLE_BITS - 16);
        end
        else
        begin : g_narrow
            assign sample_w = SB'($signed(cmd.table_sample) >>> (16 - SAMPLE_BITS));
        end
    endgenerate

    assign idx_ok    = int'(cmd.table_index) < TABLE_SIZE;
    assign tab_waddr = ADDR_W'(cmd.table_index);

    // a phase at or past the table end restarts at zero
    assign wave_wrapped = (wave_phase_reg[PHASE_W-1:PF] >= IP_W'(TABLE_SIZE)) ? '0
                                                                               : wave_phase_reg;
    assign lfo_wrapped  = (lfo_phase_reg[PHASE_W-1:PF] >= IP_W'(TABLE_SIZE)) ? '0
                                                                              : lfo_phase_reg;
    assign wave_raddr   = wave_wrapped[PF +: ADDR_W];
    assign lfo_raddr    = lfo_wrapped[PF +: ADDR_W];

    awv_ram #(
        .WIDTH (SB),
        .DEPTH (TABLE_SIZE)
    ) u_wave_ram (
        .clk   (clk),
        .we    (ctl.wave_we && idx_ok),
        .waddr (tab_waddr),
        .wdata (sample_w),
        .raddr (wave_raddr),
        .rdata (wave_rdata)
    );

    awv_ram #(
        .WIDTH (SB),
        .DEPTH (TABLE_SIZE)
    ) u_lfo_ram (
        .clk   (clk),
        .we    (ctl.lfo_we && idx_ok),
        .waddr (tab_waddr),
        .wdata (sample_w),
        .raddr (lfo_raddr),
        .rdata (lfo_rdata)
    );

    assign wave_rd = wave_rdata;
    assign lfo_rd  = lfo_rdata;

    // ---------------- envelope ----------------
    always_comb
    begin
        env_sum     = $signed({2'b00, env_reg});
        stage_calc  = stage_reg;
        active_calc = active_reg;
        if (!released_reg)
        begin
            case (stage_reg)
                STAGE_ATTACK: env_sum = env_sum + $signed({2'b00, attack_reg});
                STAGE_DECAY:  env_sum = env_sum - $signed({2'b00, decay_reg});
                default:      env_sum = $signed({2'b00, sustain_reg});
            endcase
            if (env_sum < 0)
            begin
                env_sum = '0;
            end
            if (env_sum > $signed({2'b00, awv_pkg::ENV_ONE}))
            begin
                stage_calc = STAGE_DECAY;
                env_sum    = $signed({2'b00, awv_pkg::ENV_ONE});
            end
            if (stage_calc == STAGE_DECAY && env_sum < $signed({2'b00, sustain_reg}))
            begin
                stage_calc = STAGE_SUSTAIN;
            end
        end
        else if (env_reg != '0)
        begin
            if (env_reg > sustain_reg)
            begin
                env_sum = $signed({2'b00, sustain_reg});
            end
            env_sum = env_sum - $signed({2'b00, release_reg});
            if (env_sum < 0)
            begin
                env_sum = '0;
            end
        end
        else
        begin
            active_calc = 1'b0;
        end
        env_calc = mode_reg[0] ? env_sum[ENV_W-1:0] : awv_pkg::ENV_ONE;
    end

    assign in_delay = delay_cnt_reg < start_delay_reg;

    // ---------------- voice state update ----------------
    always_comb
    begin
        wave_phase_next = wave_phase_reg;
        lfo_phase_next  = lfo_phase_reg;
        note_step_next  = note_step_reg;
        delay_cnt_next  = delay_cnt_reg;
        env_next        = env_reg;
        stage_next      = stage_reg;
        released_next   = released_reg;
        active_next     = active_reg;
        if (ctl.note_on)
        begin
            released_next   = 1'b0;
            active_next     = 1'b1;
            delay_cnt_next  = '0;
            wave_phase_next = '0;
            lfo_phase_next  = '0;
            note_step_next  = cmd.phase_step;
            if (mode_reg[0])
            begin
                env_next   = '0;
                stage_next = STAGE_ATTACK;
            end
        end
        if (ctl.note_end)
        begin
            if (mode_reg[0])
            begin
                released_next = 1'b1;
            end
            else
            begin
                env_next = '0;
            end
        end
        if (ctl.env_run)
        begin
            if (in_delay)
            begin
                delay_cnt_next  = delay_cnt_reg + 16'd1;
                wave_phase_next = wave_wrapped;
                lfo_phase_next  = lfo_wrapped;
            end
            else
            begin
                env_next        = env_calc;
                stage_next      = stage_calc;
                active_next     = active_calc;
                wave_phase_next = wave_wrapped + PHASE_W'(note_step_reg);
                lfo_phase_next  = lfo_wrapped + PHASE_W'(lfo_step_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_phase_reg <= '0;
            lfo_phase_reg  <= '0;
            note_step_reg  <= '0;
            delay_cnt_reg  <= '0;
            env_reg        <= '0;
            stage_reg      <= STAGE_ATTACK;
            released_reg   <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            wave_phase_reg <= wave_phase_next;
            lfo_phase_reg  <= lfo_phase_next;
            note_step_reg  <= note_step_next;
            delay_cnt_reg  <= delay_cnt_next;
            env_reg        <= env_next;
            stage_reg      <= stage_next;
            released_reg   <= released_next;
            active_reg     <= active_next;
        end
    end

    // ---------------- tick arithmetic ----------------
    // w*l*mix is split as (a_hi * 2^SB + a_lo) * mix to keep multipliers narrow
    always_comb
    begin
        w_next      = active_reg ? wave_rd : '0;
        a_next      = w_next * lfo_rd;
        nogain_next = in_delay;
        lo_next     = LO_W'(a_reg[SB-1:0]) * LO_W'(lfo_mix_reg);
        scale_next  = nogain_reg ? '0
                                 : awv_pkg::SCALE_W'(env_reg) *
                                   awv_pkg::SCALE_W'(awv_pkg::DAC_GAIN);
        hi_next     = $signed(a_reg[A_W-1:SB]) * $signed({1'b0, lfo_mix_reg});
        p_full      = (P_W'(hi_reg) <<< SB) + $signed(P_W'(lo_reg));
        lfo_term    = p_full >>> LFO_SHIFT;
        wm_next     = mode_reg[1] ? (WM_W'(w_reg) - WM_W'(lfo_term)) : WM_W'(w_reg);
        prod_next   = $signed({1'b0, scale_reg}) * wm_reg;
        dac_off     = prod_reg >>> DAC_SHIFT;
        dac_sum     = awv_pkg::DAC_SUM_W'(dac_off) +
                      awv_pkg::DAC_SUM_W'(awv_pkg::DAC_BIAS);
        if (dac_sum < 0)
        begin
            res_next.dac_value = '0;
        end
        else if (dac_sum > awv_pkg::DAC_SUM_W'(awv_pkg::DAC_MAX))
        begin
            res_next.dac_value = awv_pkg::DAC_W'(awv_pkg::DAC_MAX);
        end
        else
        begin
            res_next.dac_value = dac_sum[awv_pkg::DAC_W-1:0];
        end
        res_next.voice_active = active_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.env_run)
        begin
            w_reg      <= w_next;
            a_reg      <= a_next;
            nogain_reg <= nogain_next;
        end
        if (ctl.mul_lo)
        begin
            lo_reg    <= lo_next;
            scale_reg <= scale_next;
        end
        if (ctl.mul_hi)
        begin
            hi_reg <= hi_next;
        end
        if (ctl.mix)
        begin
            wm_reg <= wm_next;
        end
        if (ctl.mul_out)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.load_out)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* bench/adsr_wavetable_voice_core_tb.sv */
// ----------------------------------------------------------------------------
// adsr_wavetable_voice_core_tb
// Self-checking bench for the wavetable voice core. Both tables are loaded
// first, then directed envelope and no-envelope passes, randomized note
// sequences under many register settings, a long receiver hold-off and a
// final run with no idling. Every tick result is compared against a
// cycle-free voice predictor kept inside the bench.
// ----------------------------------------------------------------------------
module adsr_wavetable_voice_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;
    localparam int LFO_SHIFT   = 30;
    localparam int DAC_SHIFT   = 31;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 100;

    // kinds the block must ignore
    localparam logic [2:0] KIND_SPARE5 = 3'd5;
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    typedef enum logic [1:0] {
        STG_ATTACK  = 2'd0,
        STG_DECAY   = 2'd1,
        STG_SUSTAIN = 2'd2
    } env_stage_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cmd_valid;
    logic                          cmd_ready;
    awv_pkg::in_item_t             cmd;
    logic                          res_valid;
    logic                          res_ready;
    awv_pkg::out_item_t            res;
    logic                          cfg_we;
    logic [awv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [awv_pkg::CFG_W-1:0]     cfg_data;

    adsr_wavetable_voice_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers
    logic [1:0]  reg_mode;
    logic [15:0] reg_delay;
    logic [15:0] reg_mix;
    logic [23:0] reg_lfo_step;
    logic [16:0] reg_sustain;
    logic [16:0] reg_attack;
    logic [16:0] reg_decay;
    logic [16:0] reg_release;

    // predictor copy of the voice
    logic [24:0]        wave_ph;
    logic [24:0]        lfo_ph;
    logic [23:0]        note_inc;
    logic [15:0]        delay_cnt;
    logic [16:0]        env_lvl;
    env_stage_t         env_stg;
    logic               released;
    logic               sounding;
    logic signed [15:0] wave_mem [TABLE_DEPTH];
    logic signed [15:0] lfo_mem  [TABLE_DEPTH];

    awv_pkg::out_item_t dac_expected[$];

    int  errors;
    int  items_sent;
    int  ticks_checked;
    int  settings_used;
    bit  send_gaps;
    bit  recv_stalls;
    bit  long_hold;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTS)
        begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        errors++;
    endtask

    task automatic reset_voice();
        reg_mode     = '0;
        reg_delay    = '0;
        reg_mix      = awv_pkg::LFO_MIX_RESET;
        reg_lfo_step = '0;
        reg_sustain  = '0;
        reg_attack   = '0;
        reg_decay    = '0;
        reg_release  = '0;
        wave_ph      = '0;
        lfo_ph       = '0;
        note_inc     = '0;
        delay_cnt    = '0;
        env_lvl      = '0;
        env_stg      = STG_ATTACK;
        released     = 1'b0;
        sounding     = 1'b0;
    endtask

    task automatic apply_reg(input logic [awv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [awv_pkg::CFG_W-1:0] val);
        case (idx)
            awv_pkg::CFG_MODE:        reg_mode     = val[1:0];
            awv_pkg::CFG_START_DELAY: reg_delay    = val[15:0];
            awv_pkg::CFG_LFO_MIX:     reg_mix      = val[15:0];
            awv_pkg::CFG_LFO_STEP:    reg_lfo_step = val[23:0];
            awv_pkg::CFG_SUSTAIN:     reg_sustain  = val[16:0];
            awv_pkg::CFG_ATTACK:      reg_attack   = val[16:0];
            awv_pkg::CFG_DECAY:       reg_decay    = val[16:0];
            awv_pkg::CFG_RELEASE:     reg_release  = val[16:0];
            default:                  ;
        endcase
    endtask

    task automatic advance_envelope();
        longint e;
        longint sus;
        e   = longint'(env_lvl);
        sus = longint'(reg_sustain);
        if (!released)
        begin
            case (env_stg)
                STG_ATTACK: e = e + longint'(reg_attack);
                STG_DECAY:  e = e - longint'(reg_decay);
                default:    e = sus;
            endcase
            if (e < 0)
                e = 0;
            // clamp tests the new level, then decay starts
            if (e > longint'(awv_pkg::ENV_ONE))
            begin
                env_stg = STG_DECAY;
                e       = longint'(awv_pkg::ENV_ONE);
            end
            if (env_stg == STG_DECAY && e < sus)
                env_stg = STG_SUSTAIN;
        end
        else if (e > 0)
        begin
            if (e > sus)
                e = sus;
            e = e - longint'(reg_release);
            if (e < 0)
                e = 0;
        end
        else
        begin
            sounding = 1'b0;
        end
        env_lvl = e[16:0];
    endtask

    task automatic predict_item(input awv_pkg::in_item_t it);
        longint             w;
        longint             l;
        longint             prod;
        longint             dac;
        awv_pkg::out_item_t want;
        case (it.kind)
            awv_pkg::KIND_NOTE_ON:
            begin
                released  = 1'b0;
                sounding  = 1'b1;
                delay_cnt = '0;
                lfo_ph    = '0;
                wave_ph   = '0;
                note_inc  = it.phase_step;
                if (reg_mode[0])
                begin
                    env_lvl = '0;
                    env_stg = STG_ATTACK;
                end
            end
            awv_pkg::KIND_NOTE_OFF:
            begin
                if (reg_mode[0])
                    released = 1'b1;
                else
                    env_lvl = '0;
            end
            awv_pkg::KIND_WAVE_WR: wave_mem[it.table_index] = it.table_sample;
            awv_pkg::KIND_LFO_WR:  lfo_mem[it.table_index]  = it.table_sample;
            awv_pkg::KIND_TICK:
            begin
                if ((wave_ph >> awv_pkg::PHASE_FRAC) >= TABLE_DEPTH)
                    wave_ph = '0;
                if ((lfo_ph >> awv_pkg::PHASE_FRAC) >= TABLE_DEPTH)
                    lfo_ph = '0;
                w = sounding ? longint'(wave_mem[wave_ph[23:16]]) : 0;
                if (reg_mode[1])
                begin
                    l    = longint'(lfo_mem[lfo_ph[23:16]]);
                    prod = w * l * longint'(reg_mix);
                    w    = w - (prod >>> LFO_SHIFT);
                end
                dac = longint'(awv_pkg::DAC_BIAS);
                if (delay_cnt < reg_delay)
                begin
                    delay_cnt = delay_cnt + 16'd1;
                end
                else
                begin
                    advance_envelope();
                    wave_ph = wave_ph + 25'(note_inc);
                    lfo_ph  = lfo_ph + 25'(reg_lfo_step);
                    if (!reg_mode[0])
                        env_lvl = awv_pkg::ENV_ONE;
                    prod = longint'(awv_pkg::DAC_GAIN) * longint'(env_lvl) * w;
                    dac  = dac + (prod >>> DAC_SHIFT);
                end
                if (dac < 0)
                    dac = 0;
                if (dac > longint'(awv_pkg::DAC_MAX))
                    dac = longint'(awv_pkg::DAC_MAX);
                want.dac_value    = dac[awv_pkg::DAC_W-1:0];
                want.voice_active = sounding;
                dac_expected.push_back(want);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input awv_pkg::out_item_t got);
        awv_pkg::out_item_t want;
        if (dac_expected.size() == 0)
        begin
            report_mismatch($sformatf("result dac=%0d with nothing expected", got.dac_value));
        end
        else
        begin
            want = dac_expected.pop_front();
            if (got.dac_value !== want.dac_value)
                report_mismatch($sformatf("dac_value %0d, expected %0d",
                                          got.dac_value, want.dac_value));
            if (got.voice_active !== want.voice_active)
                report_mismatch($sformatf("voice_active %0b, expected %0b",
                                          got.voice_active, want.voice_active));
        end
        ticks_checked++;
    endtask

    // check first, then predict, so a same-edge result never sees its own item
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (res_valid && res_ready)
                check_result(res);
            if (cmd_valid && cmd_ready)
                predict_item(cmd);
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
        end
    end

    // result side: random stalls and the long hold-off
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                res_ready <= 1'b1;
            end
            else if (recv_stalls && $urandom_range(0, 6) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input awv_pkg::in_item_t it);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        if (it.kind <= awv_pkg::KIND_LFO_WR)
            items_sent++;
    endtask

    function automatic awv_pkg::in_item_t make_item(input logic [2:0] kind);
        awv_pkg::in_item_t it;
        it.kind         = kind;
        it.phase_step   = 24'($urandom());
        it.table_index  = 8'($urandom());
        it.table_sample = 16'($urandom());
        return it;
    endfunction

    task automatic send_kind(input logic [2:0] kind);
        send_item(make_item(kind));
    endtask

    task automatic send_write(input logic [2:0] kind, input logic [7:0] idx,
                              input logic signed [15:0] sample);
        awv_pkg::in_item_t it;
        it              = make_item(kind);
        it.table_index  = idx;
        it.table_sample = sample;
        send_item(it);
    endtask

    task automatic send_note_on(input logic [23:0] step);
        awv_pkg::in_item_t it;
        it            = make_item(awv_pkg::KIND_NOTE_ON);
        it.phase_step = step;
        send_item(it);
    endtask

    // lets every expected result arrive, then lets the last item settle
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (dac_expected.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [awv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [awv_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic write_regs(input logic [awv_pkg::CFG_W-1:0] mode,
                              input logic [awv_pkg::CFG_W-1:0] dly,
                              input logic [awv_pkg::CFG_W-1:0] mix,
                              input logic [awv_pkg::CFG_W-1:0] lstep,
                              input logic [awv_pkg::CFG_W-1:0] sus,
                              input logic [awv_pkg::CFG_W-1:0] att,
                              input logic [awv_pkg::CFG_W-1:0] dec,
                              input logic [awv_pkg::CFG_W-1:0] rel);
        write_reg(awv_pkg::CFG_MODE, mode);
        write_reg(awv_pkg::CFG_START_DELAY, dly);
        write_reg(awv_pkg::CFG_LFO_MIX, mix);
        write_reg(awv_pkg::CFG_LFO_STEP, lstep);
        write_reg(awv_pkg::CFG_SUSTAIN, sus);
        write_reg(awv_pkg::CFG_ATTACK, att);
        write_reg(awv_pkg::CFG_DECAY, dec);
        write_reg(awv_pkg::CFG_RELEASE, rel);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [awv_pkg::CFG_W-1:0] pick_value(input int unsigned hi);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return awv_pkg::CFG_W'(hi);
            default: return awv_pkg::CFG_W'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic write_random_regs();
        logic [awv_pkg::CFG_W-1:0] dly;
        dly = ($urandom_range(0, 9) == 0) ? awv_pkg::CFG_W'(16'hFFFF)
                                          : awv_pkg::CFG_W'($urandom_range(0, 4));
        write_regs(awv_pkg::CFG_W'($urandom_range(0, 3)), dly, pick_value(16'hFFFF),
                   pick_value(24'hFFFFFF), pick_value(awv_pkg::ENV_ONE),
                   pick_value(awv_pkg::ENV_ONE), pick_value(awv_pkg::ENV_ONE),
                   pick_value(awv_pkg::ENV_ONE));
    endtask

    function automatic logic [23:0] random_step();
        if ($urandom_range(0, 3) == 0)
            return 24'($urandom());
        return 24'($urandom_range(0, 24'h080000));
    endfunction

    // one well-formed note: on, ticks with the odd table write, off, release ticks
    task automatic play_note();
        send_note_on(random_step());
        repeat ($urandom_range(1, 12))
        begin
            if ($urandom_range(0, 9) == 0)
                send_kind($urandom_range(0, 1) ? awv_pkg::KIND_WAVE_WR
                                               : awv_pkg::KIND_LFO_WR);
            send_kind(awv_pkg::KIND_TICK);
        end
        send_kind(awv_pkg::KIND_NOTE_OFF);
        repeat ($urandom_range(1, 10))
            send_kind(awv_pkg::KIND_TICK);
    endtask

    task automatic run_items(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            if ($urandom_range(0, 4) != 0)
                play_note();
            else
                send_kind(3'($urandom_range(0, 7)));
        end
    endtask

    task automatic test_table_load();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_write(awv_pkg::KIND_WAVE_WR, 8'(i), 16'($urandom()));
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_write(awv_pkg::KIND_LFO_WR, 8'(i), 16'($urandom()));
        wait_idle();
    endtask

    // full envelope with delay, clamp, sustain, release to silence, phase wrap
    task automatic test_envelope_directed();
        write_regs(awv_pkg::CFG_W'(2'b11), awv_pkg::CFG_W'(2), awv_pkg::CFG_W'(16'hFFFF),
                   awv_pkg::CFG_W'(24'hFFFFFF), awv_pkg::CFG_W'(17'h08000),
                   awv_pkg::CFG_W'(17'd40000), awv_pkg::CFG_W'(awv_pkg::ENV_ONE),
                   awv_pkg::CFG_W'(17'h03000));
        send_write(awv_pkg::KIND_WAVE_WR, 8'h00, 16'sh7FFF);
        send_write(awv_pkg::KIND_WAVE_WR, 8'hFF, 16'sh8000);
        send_write(awv_pkg::KIND_LFO_WR, 8'h00, 16'sh8000);
        send_write(awv_pkg::KIND_LFO_WR, 8'hFF, 16'sh7FFF);
        send_kind(awv_pkg::KIND_TICK);
        send_note_on(24'hFFFFFF);
        repeat (6) send_kind(awv_pkg::KIND_TICK);
        send_kind(KIND_SPARE5);
        send_kind(KIND_SPARE6);
        send_kind(KIND_SPARE7);
        send_kind(awv_pkg::KIND_NOTE_OFF);
        repeat (5) send_kind(awv_pkg::KIND_TICK);
        wait_idle();
    endtask

    // envelope off: level forced to full, so the level that note off zeroes is full again at the next tick
    task automatic test_no_envelope_directed();
        write_regs('0, '0, '0, '0, awv_pkg::CFG_W'(awv_pkg::ENV_ONE),
                   awv_pkg::CFG_W'(awv_pkg::ENV_ONE), '0, '0);
        send_note_on(24'h010000);
        repeat (2) send_kind(awv_pkg::KIND_TICK);
        send_kind(awv_pkg::KIND_NOTE_OFF);
        repeat (2) send_kind(awv_pkg::KIND_TICK);
        wait_idle();
    endtask

    task automatic test_random_settings();
        repeat (12)
        begin
            write_random_regs();
            run_items(60);
            wait_idle();
        end
    endtask

    // result side held off while ticks keep coming, so the input stalls
    task automatic test_backpressure();
        write_regs(awv_pkg::CFG_W'(2'b11), '0, awv_pkg::CFG_W'(16'h4000),
                   awv_pkg::CFG_W'(24'h001234), awv_pkg::CFG_W'(17'h0C000),
                   awv_pkg::CFG_W'(17'h02000), awv_pkg::CFG_W'(17'h00800),
                   awv_pkg::CFG_W'(17'h00400));
        send_note_on(24'h00C000);
        long_hold = 1'b1;
        repeat (30) send_kind(awv_pkg::KIND_TICK);
        wait_idle();
    endtask

    task automatic test_no_idling();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        write_random_regs();
        run_items(150);
        wait_idle();
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        res_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        errors      = 0;
        items_sent  = 0;
        ticks_checked = 0;
        settings_used = 0;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        long_hold   = 1'b0;
        reset_voice();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_envelope_directed();
        test_no_envelope_directed();
        test_random_settings();
        test_backpressure();
        test_no_idling();

        repeat (20) @(posedge clk);
        if (dac_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", dac_expected.size()));
        $display("covered %0d items and %0d tick results under %0d register settings",
                 items_sent, ticks_checked, settings_used);
        $display("including table loads, delayed notes, release to silence and a long hold-off");
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", dac_expected.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
